@@ sv/key_event_to_keycode_mapper_macros.svh @@
// Assertion macros for the key event to keycode mapper checks.
// Used by the checker module; expects clk_i and rst_ni in scope.
`ifndef KEY_EVENT_TO_KEYCODE_MAPPER_MACROS_SVH
`define KEY_EVENT_TO_KEYCODE_MAPPER_MACROS_SVH

// Generic clocked assertion with asynchronous active-low reset.
`define KM_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("key mapper check failed");

// Shorthand on the standard clock and reset names.
`define KM_ASSERT(lbl, prop) `KM_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

@@ sv/kmap_pkg.sv @@
// Shared types and constants of the key event to keycode mapper.
// No dependencies.
package kmap_pkg;

  localparam int CODE_W = 16;

  typedef enum logic [1:0] {
    EV_PRESS    = 2'd0,
    EV_RELEASE  = 2'd1,
    EV_CPRESS   = 2'd2,
    EV_CRELEASE = 2'd3
  } ev_kind_e;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_TRANSP    = 3'd0;
  localparam logic [2:0] REG_EMPTY     = 3'd1;
  localparam logic [2:0] REG_CUST_LO   = 3'd2;
  localparam logic [2:0] REG_CUST_HI   = 3'd3;
  localparam logic [2:0] REG_DEF_LAYER = 3'd4;

  localparam logic [CODE_W-1:0] TRANSP_RST  = 16'd1;
  localparam logic [CODE_W-1:0] EMPTY_RST   = 16'd0;
  localparam logic [CODE_W-1:0] CUST_LO_RST = 16'd24576;
  localparam logic [CODE_W-1:0] CUST_HI_RST = 16'd28671;
  localparam logic [2:0]        DEF_LAYER_RST = 3'd0;

  // result queue depth
  localparam int OQ_DEPTH = 4;

endpackage

@@ sv/key_event_to_keycode_mapper.sv @@
// Key event to keycode mapper: per-key hold tracking over a layered keymap.
// Depends on kmap_pkg.
//
// Usage:
//   Input stream (s_axis_*): one transfer is either a layout write (tuser=1)
//   that stores a keycode for (layer, row, col), or a key level sample
//   (tuser=0) for (row, col) with the active layer. Samples whose level did
//   not change produce nothing.
//   Output stream (m_axis_*): events with kind in tuser, keycode in tdata and
//   tlast on the final event of one input. A press that displaces a stale
//   hold gives a release then a press.
//   Config: APB registers transparent_code, empty_code, custom_low,
//   custom_high, default_layer at byte addresses 0,4,8,12,16; write only
//   while idle.
//   Flow: an accepted item is registered into the evaluate stage, and its
//   events enter the result queue once there is room. One input per cycle
//   is taken as long as results drain; the output side moves one event per
//   cycle while m_axis_tready is high; a 4-entry queue decouples the sides.
//   Layout and key state live in synchronous memories read at acceptance;
//   the key state write-back is forwarded to the next reader.
//   Reset: a clearing pass over all KEY_ROWS*KEY_COLS*PAD_COUNT key slots
//   zeroes the key state; s_axis_tready stays low meanwhile. If
//   m_axis_tready stays low the queue fills and s_axis_tready drops.
module key_event_to_keycode_mapper
  import kmap_pkg::*;
#(
  parameter int KEY_ROWS    = 8,
  parameter int KEY_COLS    = 16,
  parameter int PAD_COUNT   = 2,
  parameter int LAYER_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] key_row, [7:3] key_col, [8] key_down, [11:9] layer_sel,
  // [27:12] layout_code, [31:28] zero
  input  logic [31:0] s_axis_tdata,
  // [0] action
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] event_code
  output logic [15:0] m_axis_tdata,
  // [1:0] event_kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int TOTAL_COLS = KEY_COLS * PAD_COUNT;
  localparam int KEY_SLOTS  = KEY_ROWS * TOTAL_COLS;
  localparam int MAP_SLOTS  = LAYER_COUNT * KEY_SLOTS;
  localparam int KW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int LW = (MAP_SLOTS > 1) ? $clog2(MAP_SLOTS) : 1;
  localparam int PW = $clog2(OQ_DEPTH);
  localparam int CW = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic              lvl;
    logic [CODE_W-1:0] held;
  } key_ent_t;

  typedef struct packed {
    ev_kind_e          kind;
    logic [CODE_W-1:0] code;
    logic              last;
  } ev_t;

  // ---------------- configuration ----------------
  logic [CODE_W-1:0] transp_q, empty_q, cust_lo_q, cust_hi_q;
  logic [2:0]        def_layer_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transp_q    <= TRANSP_RST;
      empty_q     <= EMPTY_RST;
      cust_lo_q   <= CUST_LO_RST;
      cust_hi_q   <= CUST_HI_RST;
      def_layer_q <= DEF_LAYER_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_TRANSP:    transp_q    <= pwdata[CODE_W-1:0];
        REG_EMPTY:     empty_q     <= pwdata[CODE_W-1:0];
        REG_CUST_LO:   cust_lo_q   <= pwdata[CODE_W-1:0];
        REG_CUST_HI:   cust_hi_q   <= pwdata[CODE_W-1:0];
        REG_DEF_LAYER: def_layer_q <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_TRANSP:    prdata = {16'd0, transp_q};
      REG_EMPTY:     prdata = {16'd0, empty_q};
      REG_CUST_LO:   prdata = {16'd0, cust_lo_q};
      REG_CUST_HI:   prdata = {16'd0, cust_hi_q};
      REG_DEF_LAYER: prdata = {29'd0, def_layer_q};
      default:       prdata = 32'd0;
    endcase
  end

  // ---------------- input decode ----------------
  logic [2:0]        in_row, in_layer;
  logic [4:0]        in_col;
  logic              in_down, in_ok, def_ok, s_fire;
  logic [CODE_W-1:0] in_code;
  logic [KW-1:0]     key_a;
  logic [LW-1:0]     lay_addr_a, def_addr_a;

  assign in_row   = s_axis_tdata[2:0];
  assign in_col   = s_axis_tdata[7:3];
  assign in_down  = s_axis_tdata[8];
  assign in_layer = s_axis_tdata[11:9];
  assign in_code  = s_axis_tdata[27:12];

  assign in_ok = (int'(in_row) < KEY_ROWS) && (int'(in_col) < TOTAL_COLS)
              && (int'(in_layer) < LAYER_COUNT);
  assign def_ok = int'(def_layer_q) < LAYER_COUNT;

  assign key_a      = KW'(int'(in_row) * TOTAL_COLS + int'(in_col));
  assign lay_addr_a = LW'(int'(in_layer) * KEY_SLOTS + int'(key_a));
  assign def_addr_a = def_ok ? LW'(int'(def_layer_q) * KEY_SLOTS + int'(key_a))
                             : lay_addr_a;

  assign s_fire = s_axis_tvalid & s_axis_tready;

  // ---------------- layout memory: 1 write, 2 reads ----------------
  logic [CODE_W-1:0] lay_mem [MAP_SLOTS];
  logic [CODE_W-1:0] lay_act_q, lay_def_q;

  always_ff @(posedge clk_i) begin
    if (s_fire && s_axis_tuser[0] && in_ok) begin
      lay_mem[lay_addr_a] <= in_code;
    end
    if (s_fire) begin
      lay_act_q <= lay_mem[lay_addr_a];
      lay_def_q <= lay_mem[def_addr_a];
    end
  end

  // ---------------- key state memory ----------------
  key_ent_t      key_mem [KEY_SLOTS];
  key_ent_t      km_rd_q, km_wdata;
  logic          km_we;
  logic [KW-1:0] km_waddr;
  logic          clr_busy_q;
  logic [KW-1:0] clr_idx_q;

  always_ff @(posedge clk_i) begin
    if (km_we) begin
      key_mem[km_waddr] <= km_wdata;
    end
    if (s_fire) begin
      km_rd_q <= key_mem[key_a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_idx_q == KW'(KEY_SLOTS - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_idx_q <= clr_idx_q + KW'(1);
    end
  end

  // ---------------- evaluate stage ----------------
  logic          b_vld_q, b_ok_q, b_down_q, b_defok_q;
  logic [KW-1:0] b_key_q;
  logic          fwd_vld_q;
  logic [KW-1:0] fwd_key_q;
  key_ent_t      fwd_ent_q;

  key_ent_t          cur;
  logic [CODE_W-1:0] code, cust_arg, new_held;
  logic              changed, is_cust, b_fire;
  logic [1:0]        b_n;
  ev_t               ev0, ev1;

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      b_ok_q    <= ~s_axis_tuser[0] & in_ok;
      b_down_q  <= in_down;
      b_key_q   <= key_a;
      b_defok_q <= def_ok;
    end
  end

  always_comb begin
    // latest write-back may be newer than the registered read
    cur = (fwd_vld_q && fwd_key_q == b_key_q) ? fwd_ent_q : km_rd_q;
    code = (lay_act_q == transp_q && b_defok_q) ? lay_def_q : lay_act_q;
    changed = b_vld_q && b_ok_q && (b_down_q != cur.lvl);
    cust_arg = b_down_q ? code : cur.held;
    is_cust = (cust_arg >= cust_lo_q) && (cust_arg <= cust_hi_q);

    b_n = 2'd0;
    ev0 = '{kind: EV_PRESS, code: code, last: 1'b1};
    ev1 = '{kind: EV_PRESS, code: code, last: 1'b1};
    new_held = code;
    if (changed) begin
      if (b_down_q) begin
        if (is_cust) begin
          b_n = 2'd1;
          ev0.kind = EV_CPRESS;
        end else if (code != transp_q) begin
          if (cur.held != empty_q) begin
            // stale hold is released ahead of the press
            b_n = 2'd2;
            ev0 = '{kind: EV_RELEASE, code: cur.held, last: 1'b0};
          end else begin
            b_n = 2'd1;
          end
        end
      end else begin
        b_n = 2'd1;
        new_held = empty_q;
        ev0 = '{kind: is_cust ? EV_CRELEASE : EV_RELEASE, code: cur.held,
                last: 1'b1};
      end
    end
  end

  // ---------------- result queue ----------------
  ev_t           oq [OQ_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          m_fire;

  assign b_fire = b_vld_q && ((cnt_q + CW'(b_n)) <= CW'(OQ_DEPTH));
  assign s_axis_tready = ~clr_busy_q & (~b_vld_q | b_fire);
  assign m_fire = m_axis_tvalid & m_axis_tready;

  assign km_we    = clr_busy_q | (b_fire & changed);
  assign km_waddr = clr_busy_q ? clr_idx_q : b_key_q;
  assign km_wdata = clr_busy_q ? key_ent_t'('0)
                               : key_ent_t'{lvl: b_down_q, held: new_held};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q   <= 1'b0;
      fwd_vld_q <= 1'b0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      cnt_q     <= '0;
    end else begin
      if (s_fire) begin
        b_vld_q <= 1'b1;
      end else if (b_fire) begin
        b_vld_q <= 1'b0;
      end
      if (b_fire && changed) begin
        fwd_vld_q <= 1'b1;
      end
      if (b_fire) begin
        wr_ptr_q <= wr_ptr_q + PW'(b_n);
      end
      if (m_fire) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      cnt_q <= cnt_q + (b_fire ? CW'(b_n) : CW'(0)) - (m_fire ? CW'(1) : CW'(0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire && changed) begin
      fwd_key_q <= b_key_q;
      fwd_ent_q <= km_wdata;
    end
    if (b_fire && b_n != 2'd0) begin
      oq[wr_ptr_q] <= ev0;
    end
    if (b_fire && b_n == 2'd2) begin
      oq[wr_ptr_q + PW'(1)] <= ev1;
    end
  end

  assign m_axis_tvalid = cnt_q != CW'(0);
  assign m_axis_tdata  = oq[rd_ptr_q].code;
  assign m_axis_tuser  = oq[rd_ptr_q].kind;
  assign m_axis_tlast  = oq[rd_ptr_q].last;

endmodule

@@ sv/kmap_chk.sv @@
// Port-level checks of the key event to keycode mapper, bound to the top.
// Depends on kmap_pkg and key_event_to_keycode_mapper_macros.svh.
`include "key_event_to_keycode_mapper_macros.svh"

module kmap_chk
  import kmap_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast,
  input logic        pready
);

  logic        m_fire, m_last_press;
  logic [18:0] m_beat;

  assign m_fire       = m_axis_tvalid & m_axis_tready;
  assign m_last_press = m_axis_tvalid & m_axis_tlast & (m_axis_tuser == EV_PRESS);
  assign m_beat       = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  `KM_ASSERT(a_pready_high, pready)

  `KM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_beat))

  // only a displaced hold release precedes another event of the same input
  `KM_ASSERT(a_nonlast_release, m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == EV_RELEASE)

  `KM_ASSERT(a_cpress_single, m_axis_tvalid && m_axis_tuser == EV_CPRESS |-> m_axis_tlast)

  // both events of a displacing press are queued together
  `KM_ASSERT(a_pair_follows, m_fire && !m_axis_tlast |=> m_last_press)

endmodule

bind key_event_to_keycode_mapper kmap_chk u_kmap_chk (.*);

@@ verif/key_event_to_keycode_mapper_test.sv @@
// Self-checking testbench for key_event_to_keycode_mapper: stream driver and monitor,
// an in-bench keymap predictor and APB register setup across several settings.
// Depends on kmap_pkg and the key_event_to_keycode_mapper RTL.
`timescale 1ns / 1ps

module key_event_to_keycode_mapper_test;
  import kmap_pkg::*;

  typedef struct packed {
    ev_kind_e    kind;
    logic [15:0] code;
    logic        last;
  } key_event_t;

  // one input transfer plus the events it is predicted to cause
  typedef struct packed {
    logic        action;
    logic [2:0]  row;
    logic [4:0]  col;
    logic        down;
    logic [2:0]  layer;
    logic [15:0] code;
    logic [1:0]  nev;
    key_event_t  ev0;
    key_event_t  ev1;
  } key_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  key_event_to_keycode_mapper DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // keymap shadow: settings, per-key level and hold, layered layout
  logic [15:0] cfg_transp, cfg_empty, cfg_lo, cfg_hi;
  logic [2:0]  cfg_dlayer;
  logic        prev_lvl [256];
  logic [15:0] held [256];
  logic [15:0] layout [2048];
  bit          written [2048];
  logic [7:0]  hot_keys [16];

  key_item_t   keys_to_send [$];
  key_event_t  events_due [$];
  bit          in_fire = 1'b0;
  bit          no_gaps = 1'b0;
  int unsigned mismatches = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic bit is_custom(logic [15:0] c);
    return c >= cfg_lo && c <= cfg_hi;
  endfunction

  // updates the shadow state and fills in the events the item causes
  function automatic key_item_t map_key_event(key_item_t it);
    logic [7:0]  k;
    logic [10:0] li;
    logic [15:0] c;
    key_event_t  ev [2];
    int          n;
    k = {it.row, it.col};
    li = {it.layer, k};
    n = 0;
    ev[0] = '{EV_PRESS, 16'h0, 1'b0};
    ev[1] = ev[0];
    it.nev = 2'd0;
    it.ev0 = ev[0];
    it.ev1 = ev[1];
    if (it.action) begin
      layout[li] = it.code;
      written[li] = 1'b1;
      return it;
    end
    if (it.down == prev_lvl[k]) return it;
    if (it.down) begin
      c = layout[li];
      if (c == cfg_transp) c = layout[{cfg_dlayer, k}];
      if (is_custom(c)) begin
        ev[n] = '{EV_CPRESS, c, 1'b0};
        n++;
      end else if (c != cfg_transp) begin
        // hold left over from an older empty code is released first
        if (held[k] != cfg_empty) begin
          ev[n] = '{EV_RELEASE, held[k], 1'b0};
          n++;
        end
        ev[n] = '{EV_PRESS, c, 1'b0};
        n++;
      end
      held[k] = c;
    end else begin
      c = held[k];
      held[k] = cfg_empty;
      ev[n] = '{is_custom(c) ? EV_CRELEASE : EV_RELEASE, c, 1'b0};
      n++;
    end
    prev_lvl[k] = it.down;
    if (n > 0) ev[n-1].last = 1'b1;
    it.nev = 2'(n);
    it.ev0 = ev[0];
    it.ev1 = ev[1];
    return it;
  endfunction

  function automatic key_item_t key_item(logic action, logic [2:0] layer, logic [2:0] row,
                                         logic [4:0] col, logic down, logic [15:0] code);
    key_item_t it;
    it = '0;
    it.action = action;
    it.layer = layer;
    it.row = row;
    it.col = col;
    it.down = down;
    it.code = code;
    return it;
  endfunction

  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 7))
      0: return cfg_transp;
      1: return cfg_empty;
      2: return cfg_lo;
      3: return cfg_hi;
      4: return cfg_lo - 16'd1;
      5: return cfg_hi + 16'd1;
      6: return {cfg_lo[15:8], 8'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly press/release toggles on a few keys; a press whose lookup would
  // hit an unwritten layout entry turns into a write of that entry instead
  function automatic key_item_t random_key_item();
    key_item_t   it;
    logic [7:0]  k;
    logic [10:0] li;
    it = '0;
    k = ($urandom_range(0, 9) == 0) ? 8'($urandom) : hot_keys[$urandom_range(0, 15)];
    it.row = k[7:5];
    it.col = k[4:0];
    it.layer = ($urandom_range(0, 3) == 0) ? cfg_dlayer : 3'($urandom);
    it.code = 16'($urandom);
    it.down = 1'($urandom);
    it.action = ($urandom_range(0, 3) == 0);
    if (it.action) it.code = pick_code();
    else if ($urandom_range(0, 9) < 7) it.down = !prev_lvl[k];
    if (!it.action && it.down && !prev_lvl[k]) begin
      li = {it.layer, k};
      if (!written[li]) begin
        it.action = 1'b1;
        it.code = pick_code();
      end else if (layout[li] == cfg_transp && !written[{cfg_dlayer, k}]) begin
        it.action = 1'b1;
        it.layer = cfg_dlayer;
        it.code = pick_code();
      end
    end
    return it;
  endfunction

  task automatic send_key(key_item_t it);
    keys_to_send.push_back(map_key_event(it));
  endtask

  // APB write followed by a read back of the same register
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    logic [31:0] rd;
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = {16'h0, val};
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    if (rd !== {16'h0, val})
      note_mismatch($sformatf("reg %0d read exp %h got %h", idx, val, rd));
    case (idx)
      REG_TRANSP:    cfg_transp = val;
      REG_EMPTY:     cfg_empty = val;
      REG_CUST_LO:   cfg_lo = val;
      REG_CUST_HI:   cfg_hi = val;
      REG_DEF_LAYER: cfg_dlayer = val[2:0];
      default: ;
    endcase
  endtask

  // driver
  always @(negedge clk_i) begin
    logic gap;
    gap = !no_gaps && ($urandom_range(0, 99) < 19);
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (in_fire) void'(keys_to_send.pop_front());
      if (s_axis_tvalid && !in_fire) begin
        // hold the transfer until it is taken
      end else if (keys_to_send.size() > 0 && !gap) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'h0, keys_to_send[0].code, keys_to_send[0].layer,
                         keys_to_send[0].down, keys_to_send[0].col, keys_to_send[0].row};
        s_axis_tuser <= keys_to_send[0].action;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 19);
  end

  // monitor: queues expectations on input transfers, checks output transfers
  always @(posedge clk_i) begin
    key_event_t want;
    in_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_fire) begin
      if (keys_to_send[0].nev > 0) events_due.push_back(keys_to_send[0].ev0);
      if (keys_to_send[0].nev > 1) events_due.push_back(keys_to_send[0].ev1);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (events_due.size() == 0) begin
        note_mismatch($sformatf("unexpected event kind %0d code %h last %0b",
                                m_axis_tuser, m_axis_tdata, m_axis_tlast));
      end else begin
        want = events_due.pop_front();
        if (m_axis_tuser !== want.kind || m_axis_tdata !== want.code ||
            m_axis_tlast !== want.last)
          note_mismatch($sformatf("kind exp %0d got %0d, code exp %h got %h, last exp %0b got %0b",
                                  want.kind, m_axis_tuser, want.code, m_axis_tdata,
                                  want.last, m_axis_tlast));
      end
    end
  end

  initial begin
    logic [2:0]  reg_idx [5];
    logic [15:0] reg_plan [8][5];
    reg_idx = '{REG_TRANSP, REG_EMPTY, REG_CUST_LO, REG_CUST_HI, REG_DEF_LAYER};
    // order: transparent, empty, custom low, custom high, default layer
    reg_plan[1] = '{16'h0000, 16'hFFFF, 16'h8000, 16'hFFFE, 16'd7};
    reg_plan[2] = '{16'hFFFF, 16'h0001, 16'hFFFF, 16'h0000, 16'd3};  // no custom codes
    reg_plan[3] = '{16'h6100, 16'h0000, 16'h6000, 16'h6FFF, 16'd0};  // transparent is custom
    reg_plan[4] = '{16'h0002, 16'h0002, 16'h0000, 16'hFFFF, 16'd5};  // everything custom
    reg_plan[5] = '{16'h1234, 16'h0000, 16'h1234, 16'h1234, 16'd1};
    reg_plan[6] = '{TRANSP_RST, EMPTY_RST, CUST_LO_RST, CUST_HI_RST, 16'(DEF_LAYER_RST)};
    reg_plan[7] = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom_range(0, 7))};
    cfg_transp = TRANSP_RST;
    cfg_empty = EMPTY_RST;
    cfg_lo = CUST_LO_RST;
    cfg_hi = CUST_HI_RST;
    cfg_dlayer = DEF_LAYER_RST;
    for (int i = 0; i < 256; i++) begin
      prev_lvl[i] = 1'b0;
      held[i] = 16'h0;
    end
    for (int i = 0; i < 2048; i++) written[i] = 1'b0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    send_key(key_item(1'b1, 3'd0, 3'd0, 5'd0, 1'b1, 16'h0004));
    send_key(key_item(1'b1, 3'd7, 3'd7, 5'd31, 1'b0, 16'hFFFF));
    send_key(key_item(1'b1, 3'd0, 3'd7, 5'd31, 1'b0, CUST_LO_RST));
    send_key(key_item(1'b1, 3'd3, 3'd7, 5'd31, 1'b0, TRANSP_RST));
    send_key(key_item(1'b0, 3'd0, 3'd0, 5'd0, 1'b1, 16'hFFFF));
    send_key(key_item(1'b0, 3'd0, 3'd0, 5'd0, 1'b1, 16'h0000));  // level unchanged
    send_key(key_item(1'b0, 3'd0, 3'd0, 5'd0, 1'b0, 16'h5A5A));
    send_key(key_item(1'b0, 3'd3, 3'd7, 5'd31, 1'b1, 16'h0));    // falls through to layer 0
    send_key(key_item(1'b0, 3'd3, 3'd7, 5'd31, 1'b0, 16'h0));
    send_key(key_item(1'b0, 3'd7, 3'd7, 5'd31, 1'b1, 16'h0));
    send_key(key_item(1'b0, 3'd7, 3'd7, 5'd31, 1'b0, 16'h0));
    // transparent in both layers: silent press, then release of the transparent hold
    send_key(key_item(1'b1, 3'd5, 3'd3, 5'd17, 1'b0, TRANSP_RST));
    send_key(key_item(1'b1, 3'd0, 3'd3, 5'd17, 1'b0, TRANSP_RST));
    send_key(key_item(1'b0, 3'd5, 3'd3, 5'd17, 1'b1, 16'h0));
    send_key(key_item(1'b0, 3'd5, 3'd3, 5'd17, 1'b0, 16'h0));
    send_key(key_item(1'b1, 3'd2, 3'd4, 5'd8, 1'b0, CUST_HI_RST));
    send_key(key_item(1'b0, 3'd2, 3'd4, 5'd8, 1'b1, 16'h0));
    send_key(key_item(1'b0, 3'd2, 3'd4, 5'd8, 1'b0, 16'h0));
    // code equal to the empty code: pressed and released like any other
    send_key(key_item(1'b1, 3'd1, 3'd1, 5'd2, 1'b1, EMPTY_RST));
    send_key(key_item(1'b0, 3'd1, 3'd1, 5'd2, 1'b1, 16'h0));
    send_key(key_item(1'b0, 3'd1, 3'd1, 5'd2, 1'b0, 16'h0));
    send_key(key_item(1'b0, 3'd4, 3'd6, 5'd9, 1'b0, 16'h0));

    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        wait (keys_to_send.size() == 0 && events_due.size() == 0);
        repeat (8) @(posedge clk_i);
        for (int r = 0; r < 5; r++) write_reg(reg_idx[r], reg_plan[p][r]);
        @(posedge clk_i);
      end
      no_gaps = (p == 3);
      for (int i = 0; i < 16; i++) hot_keys[i] = 8'($urandom);
      repeat (200) send_key(random_key_item());
    end

    wait (keys_to_send.size() == 0 && events_due.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
